// ----- src/isu_pkg.sv -----
// ----------------------------------------------------------------------------
// isu_pkg
// Shared types and constants for the interval set membership and union block.
// ----------------------------------------------------------------------------
package isu_pkg;

	localparam int MAX_RANGES = 64;
	localparam int ID_BITS    = 52;
	localparam int IDX_W      = $clog2(MAX_RANGES);
	localparam int CNT_W      = $clog2(MAX_RANGES + 1);
	localparam int SUM_W      = ID_BITS + 1;
	localparam int HIT_W      = 32;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_UNION = 2'd2;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_FULL  = 2'd1;
	localparam logic [1:0] ERR_ORDER = 2'd2;

	typedef enum logic [1:0] {
		EV_QUERY,
		EV_FIND,
		EV_EXT
	} ev_mode_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [ID_BITS-1:0] range_start;
		logic [ID_BITS-1:0] range_end;
		logic [ID_BITS-1:0] item_id;
	} req_t;

	typedef struct packed {
		logic             in_range;
		logic [HIT_W-1:0] hit_count;
		logic [SUM_W-1:0] union_size;
		logic [6:0]       stored_ranges;
		logic [1:0]       error;
	} rsp_t;

	typedef struct packed {
		logic             capture;
		logic             load;
		logic             clr_hit;
		logic             clr_union;
		logic             clr_found;
		logic             clr_chg;
		logic             accum;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             eval;
		ev_mode_t         mode;
		logic             finish;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] total;
		logic             found;
		logic             chg;
		logic             out_free;
	} stat_t;

endpackage

// ----- src/isu_dp.sv -----
// ----------------------------------------------------------------------------
// isu_dp
// Range table, scan compare logic, union accumulator and result register.
// ----------------------------------------------------------------------------
module isu_dp import isu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  cmd_t  cmd,
	output stat_t stat,
	input  logic  rsp_stall,
	output logic  rsp_valid,
	output rsp_t  rsp
);

	logic [2*ID_BITS-1:0] mem [MAX_RANGES];
	logic [2*ID_BITS-1:0] rd_q;
	req_t                 req_q;
	logic [CNT_W-1:0]     total_q;
	logic [HIT_W-1:0]     hits_q;
	logic                 out_valid_q;
	rsp_t                 rsp_q;
	logic                 hit_q, found_q, chg_q;
	logic [SUM_W-1:0]     s_q, e_q, pos_q, sum_q;
	logic [1:0]           err_q;

	logic [SUM_W-1:0] lo, hi, idv, cand, e1;
	logic             full, bad_order, load_ok;
	logic [HIT_W-1:0] hits_nx;
	logic [1:0]       err;

	assign lo   = {1'b0, rd_q[2*ID_BITS-1:ID_BITS]};
	assign hi   = {1'b0, rd_q[ID_BITS-1:0]};
	assign idv  = {1'b0, req_q.item_id};
	assign cand = (lo > pos_q) ? lo : pos_q;
	assign e1   = e_q + SUM_W'(1);

	assign full      = total_q >= CNT_W'(MAX_RANGES);
	assign bad_order = req_q.range_start > req_q.range_end;
	assign load_ok   = !full && !bad_order;
	assign err       = full ? ERR_FULL : (bad_order ? ERR_ORDER : ERR_OK);

	always_comb begin
		hits_nx = hits_q;
		if (req_q.operation == OP_QUERY && hit_q && hits_q != '1)
			hits_nx = hits_q + HIT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			req_q <= req;
		// hold the load status before the range count moves on
		if (cmd.load)
			err_q <= err;
		if (cmd.load && load_ok)
			mem[total_q[IDX_W-1:0]] <= {req_q.range_start, req_q.range_end};
		if (cmd.rd_en)
			rd_q <= mem[cmd.rd_addr];
	end

	// scan evaluation and union bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.clr_hit)
			hit_q <= 1'b0;
		if (cmd.clr_union) begin
			sum_q <= '0;
			pos_q <= '0;
		end
		if (cmd.clr_found)
			found_q <= 1'b0;
		if (cmd.clr_chg)
			chg_q <= 1'b0;
		if (cmd.accum) begin
			sum_q <= sum_q + (e_q - s_q) + SUM_W'(1);
			pos_q <= e1;
		end
		if (cmd.eval) begin
			case (cmd.mode)
				EV_QUERY: begin
					if (lo <= idv && idv <= hi)
						hit_q <= 1'b1;
				end
				EV_FIND: begin
					if (hi >= pos_q && (!found_q || cand < s_q)) begin
						s_q     <= cand;
						e_q     <= hi;
						found_q <= 1'b1;
					end
				end
				EV_EXT: begin
					if (lo <= e1 && hi > e_q) begin
						e_q   <= hi;
						chg_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			hits_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && load_ok)
				total_q <= total_q + CNT_W'(1);
			if (cmd.finish) begin
				hits_q      <= hits_nx;
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.in_range      <= (req_q.operation == OP_QUERY) && hit_q;
			rsp_q.hit_count     <= hits_nx;
			rsp_q.union_size    <= (req_q.operation == OP_UNION) ? sum_q : '0;
			rsp_q.stored_ranges <= 7'(total_q);
			rsp_q.error         <= (req_q.operation == OP_LOAD) ? err_q : ERR_OK;
		end
	end

	assign stat.total    = total_q;
	assign stat.found    = found_q;
	assign stat.chg      = chg_q;
	assign stat.out_free = !out_valid_q || !rsp_stall;
	assign rsp_valid     = out_valid_q;
	assign rsp           = rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_RANGES))
		else $error("range count beyond table depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accum |-> found_q && !chg_q)
		else $error("union segment added without a found start");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("result beat lost");

endmodule

// ----- src/isu_ctrl.sv -----
// ----------------------------------------------------------------------------
// isu_ctrl
// Sequencer: accepts a beat, runs the table scans and hands off the result.
// ----------------------------------------------------------------------------
module isu_ctrl import isu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] op_in,
	output logic       req_stall,
	input  stat_t      stat,
	output cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] idx_q;
	ev_mode_t         mode_q;
	logic             eval_q;
	logic             accept, scan_done;

	assign req_stall = state_q != ST_IDLE;
	assign accept    = req_valid && state_q == ST_IDLE;
	assign scan_done = state_q == ST_SCAN && !eval_q && idx_q >= stat.total;

	always_comb begin
		cmd         = '0;
		cmd.capture = accept;
		cmd.rd_en   = state_q == ST_SCAN && idx_q < stat.total;
		cmd.rd_addr = idx_q[IDX_W-1:0];
		cmd.eval    = eval_q;
		cmd.mode    = mode_q;
		cmd.load    = state_q == ST_LOAD;
		cmd.finish  = state_q == ST_FINISH && stat.out_free;
		if (accept) begin
			cmd.clr_hit   = op_in == OP_QUERY;
			cmd.clr_union = op_in == OP_UNION;
			cmd.clr_found = op_in == OP_UNION;
		end
		if (scan_done) begin
			case (mode_q)
				EV_FIND: cmd.clr_chg = stat.found;
				EV_EXT: begin
					cmd.clr_chg   = stat.chg;
					cmd.accum     = !stat.chg;
					cmd.clr_found = !stat.chg;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			mode_q  <= EV_QUERY;
			eval_q  <= 1'b0;
		end else begin
			eval_q <= cmd.rd_en;
			if (cmd.rd_en)
				idx_q <= idx_q + CNT_W'(1);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						case (op_in)
							OP_LOAD:  state_q <= ST_LOAD;
							OP_QUERY: begin
								state_q <= ST_SCAN;
								mode_q  <= EV_QUERY;
							end
							OP_UNION: begin
								state_q <= ST_SCAN;
								mode_q  <= EV_FIND;
							end
							default:  state_q <= ST_FINISH;
						endcase
					end
				end
				ST_LOAD: state_q <= ST_FINISH;
				ST_SCAN: begin
					if (scan_done) begin
						idx_q <= '0;
						case (mode_q)
							EV_FIND: begin
								if (stat.found)
									mode_q <= EV_EXT;
								else
									state_q <= ST_FINISH;
							end
							// extend again while the segment grew, else look for the next one
							EV_EXT: mode_q <= stat.chg ? EV_EXT : EV_FIND;
							default: state_q <= ST_FINISH;
						endcase
					end
				end
				ST_FINISH: begin
					if (stat.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> idx_q <= stat.total)
		else $error("scan index ran past the table");
	assert property (@(posedge clk) disable iff (!arst_n)
		eval_q |-> $past(state_q) == ST_SCAN)
		else $error("evaluation outside a scan");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_FINISH)
		else $error("load not followed by result");

endmodule

// ----- src/interval_set_membership_and_union.sv -----
// ----------------------------------------------------------------------------
// interval_set_membership_and_union
// Range table with ID membership query and union size report.
// ----------------------------------------------------------------------------
// A load goes from accept through the load and finish states to the result; a query
//   scans every stored range once. A union report scans the table once per search
//   or extension; passes number about twice the disjoint segments plus merges.
// One item at a time: the next beat is taken once the result is registered.
// Reset clears the range count, hit counter and sequencer; table entries keep
//   no reset and are read only below the range count.
module interval_set_membership_and_union import isu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t  cmd;
	stat_t stat;

	isu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.op_in     (req.operation),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	isu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives loads, ID queries and union reports into the range table with random
// idling and stalls, and checks every response against a behavioural model.
// ----------------------------------------------------------------------------
module testbench import isu_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int         CYCLE_LIMIT = 20000000;
	localparam logic [ID_BITS-1:0] ID_TOP = {ID_BITS{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	interval_set_membership_and_union uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model state
	logic [ID_BITS-1:0] tbl_lo [MAX_RANGES];
	logic [ID_BITS-1:0] tbl_hi [MAX_RANGES];
	int                 tbl_cnt = 0;
	logic [HIT_W-1:0]   hits = '0;

	rsp_t pending_rsp [$];
	int   mismatches = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	bit   hold_off = 1'b0;
	longint cycles = 0;

	function automatic logic [SUM_W-1:0] union_span();
		logic [ID_BITS-1:0] lo [$];
		logic [ID_BITS-1:0] hi [$];
		logic [ID_BITS-1:0] cl, ch, tl, th;
		logic [SUM_W-1:0] total;
		int m;
		total = '0;
		for (int k = 0; k < tbl_cnt; k++) begin
			lo.push_back(tbl_lo[k]);
			hi.push_back(tbl_hi[k]);
		end
		if (lo.size() == 0) return '0;
		// insertion sort by lower bound
		for (int k = 1; k < lo.size(); k++) begin
			tl = lo[k]; th = hi[k]; m = k;
			while (m > 0 && lo[m-1] > tl) begin
				lo[m] = lo[m-1]; hi[m] = hi[m-1]; m--;
			end
			lo[m] = tl; hi[m] = th;
		end
		cl = lo[0]; ch = hi[0];
		for (int k = 1; k < lo.size(); k++) begin
			if (lo[k] <= ch) begin
				if (hi[k] > ch) ch = hi[k];
			end else begin
				total += SUM_W'(ch - cl) + 1;
				cl = lo[k]; ch = hi[k];
			end
		end
		total += SUM_W'(ch - cl) + 1;
		return total;
	endfunction

	function automatic rsp_t table_step(req_t r);
		rsp_t o;
		o = '0;
		case (r.operation)
			OP_LOAD: begin
				if (tbl_cnt >= MAX_RANGES) o.error = ERR_FULL;
				else if (r.range_start > r.range_end) o.error = ERR_ORDER;
				else begin
					tbl_lo[tbl_cnt] = r.range_start;
					tbl_hi[tbl_cnt] = r.range_end;
					tbl_cnt++;
				end
			end
			OP_QUERY: begin
				for (int k = 0; k < tbl_cnt; k++)
					if (r.item_id >= tbl_lo[k] && r.item_id <= tbl_hi[k]) o.in_range = 1'b1;
				if (o.in_range && hits != '1) hits++;
			end
			OP_UNION: o.union_size = union_span();
			default: ;
		endcase
		o.hit_count = hits;
		o.stored_ranges = 7'(tbl_cnt);
		return o;
	endfunction

	task automatic send_beat(req_t r);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_rsp.push_back(table_step(r));
	endtask

	task automatic drain();
		if (pending_rsp.size() != 0) begin
			req_valid <= 1'b0;
			while (pending_rsp.size() != 0) @(posedge clk);
		end
	endtask

	function automatic logic [ID_BITS-1:0] rand_id();
		logic [ID_BITS-1:0] v;
		v = ID_BITS'({$urandom, $urandom});
		case ($urandom_range(3))
			0: v = v & 52'hFF;
			1: v = ID_TOP - (v & 52'hFF);
			default: ;
		endcase
		return v;
	endfunction

	function automatic req_t rand_item(int load_pct);
		req_t r;
		logic [ID_BITS-1:0] a, b;
		int p;
		r = '0;
		p = $urandom_range(99);
		a = rand_id();
		b = ($urandom_range(3) == 0) ? rand_id() : a + ($urandom & 32'hFFF);
		if (b < a && $urandom_range(3) != 0) b = ID_TOP;
		r.range_start = a;
		r.range_end = b;
		r.item_id = (tbl_cnt > 0 && $urandom_range(1))
			? tbl_lo[$urandom_range(tbl_cnt-1)] + ($urandom & 32'hFFF) : rand_id();
		if (p < load_pct) r.operation = OP_LOAD;
		else if (p < 85) r.operation = OP_QUERY;
		else if (p < 97) r.operation = OP_UNION;
		else r.operation = OP_SPARE;
		return r;
	endfunction

	// receiver
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response %p", rsp);
			end else begin
				rsp_t e;
				e = pending_rsp.pop_front();
				if (rsp !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", e, rsp);
				end
			end
		end
		rsp_stall <= hold_off || (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	typedef struct {
		req_t r;
		bit   checked;
		rsp_t want;
	} stim_row_t;

	initial begin
		stim_row_t rows [$];
		req_t r;
		int loads;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: empty table, extremes, order error, spare op
		rows.push_back('{'{OP_QUERY, '0, '0, '0}, 1, '{0, 0, 0, 0, ERR_OK}});
		rows.push_back('{'{OP_UNION, '0, '0, '0}, 1, '{0, 0, 0, 0, ERR_OK}});
		rows.push_back('{'{OP_LOAD, ID_TOP, '0, '0}, 1, '{0, 0, 0, 0, ERR_ORDER}});
		rows.push_back('{'{OP_SPARE, ID_TOP, ID_TOP, ID_TOP}, 1, '{0, 0, 0, 0, ERR_OK}});
		rows.push_back('{'{OP_LOAD, '0, ID_TOP, '0}, 1, '{0, 0, 0, 1, ERR_OK}});
		rows.push_back('{'{OP_UNION, '0, '0, '0}, 1,
			'{0, 0, {1'b1, {ID_BITS{1'b0}}}, 1, ERR_OK}});
		rows.push_back('{'{OP_QUERY, '0, '0, ID_TOP}, 1, '{1, 1, 0, 1, ERR_OK}});
		rows.push_back('{'{OP_QUERY, '0, '0, '0}, 1, '{1, 2, 0, 1, ERR_OK}});
		rows.push_back('{'{OP_LOAD, 52'd5, 52'd5, '0}, 0, '0});
		rows.push_back('{'{OP_LOAD, 52'd5, 52'd5, '0}, 0, '0});
		rows.push_back('{'{OP_LOAD, ID_TOP, ID_TOP, '0}, 0, '0});
		rows.push_back('{'{OP_UNION, '0, '0, '0}, 0, '0});
		rows.push_back('{'{OP_QUERY, '0, '0, 52'd5}, 0, '0});
		foreach (rows[i]) begin
			if (rows[i].checked) begin
				rsp_t m;
				drain();
				m = table_step(rows[i].r);
				if (m !== rows[i].want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("table row %0d: expected %p model %p", i, rows[i].want, m);
				end
				// undo the model step, send_beat repeats it
				if (rows[i].r.operation == OP_LOAD && m.error == ERR_OK) tbl_cnt--;
				if (m.in_range && hits != '1) hits--;
				else if (m.in_range) hits = hits;
			end
			send_beat(rows[i].r);
		end
		drain();

		// fill the table, then one load into the full table and a union report
		while (tbl_cnt < MAX_RANGES) begin
			r = rand_item(100);
			if (r.range_start > r.range_end) r.range_end = r.range_start;
			send_beat(r);
		end
		send_beat('{OP_LOAD, ID_TOP, '0, '0});
		send_beat('{OP_UNION, '0, '0, '0});

		// long receiver hold-off with the sender still offering
		hold_off = 1'b1;
		fork
			begin repeat (300) @(posedge clk); hold_off = 1'b0; end
			for (int i = 0; i < 6; i++) send_beat(rand_item(10));
		join
		drain();

		// saturate the hit counter by jumping the model is impossible; keep count
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 87 : 0;
			recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 9 : 0;
			for (int i = 0; i < 460; i++) begin
				// no table restart without reset: loads only grow the table; now and then drain
				send_beat(rand_item(tbl_cnt < MAX_RANGES ? 40 : 8));
				if ($urandom_range(199) == 0) begin
					drain();
					repeat ($urandom_range(5)) @(posedge clk);
				end
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
